/* sv/iol_pkg.sv */
`default_nettype none
package iol_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CNT_OUT_W    = 5;
    localparam int ACTION_W     = 3;

    // Number of cells that a position field can name.
    localparam int POS_REACH    = 1 << POS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND   = 3'd0,
        ACT_INS_HEAD = 3'd1,
        ACT_REM_HEAD = 3'd2,
        ACT_INS_AT   = 3'd3,
        ACT_REM_AT   = 3'd4,
        ACT_READ_AT  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_out_beat;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage
`default_nettype wire

/* sv/iol_cell.sv */
`default_nettype none
module iol_cell #(
    parameter int INDEX = 0,
    parameter int PW    = iol_pkg::POS_W
) (
    input  wire                                 i_clk,
    input  iol_pkg::t_cell_cmd                  i_cmd,
    input  wire [PW-1:0]                        i_pos,
    input  wire signed [iol_pkg::DATA_W-1:0]    i_new,
    input  wire signed [iol_pkg::DATA_W-1:0]    i_left,
    input  wire signed [iol_pkg::DATA_W-1:0]    i_right,
    output logic signed [iol_pkg::DATA_W-1:0]   o_value
);

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic signed [iol_pkg::DATA_W-1:0] r_value;
    logic signed [iol_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            // Cells above the insert point take their lower neighbor.
            if (MY_IDX > i_pos) begin
                n_value = i_left;
            end else if (MY_IDX == i_pos) begin
                n_value = i_new;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

/* sv/iol_decode.sv */
`default_nettype none
module iol_decode #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int PW       = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W
) (
    input  iol_pkg::t_in_beat   i_beat,
    input  wire [CW-1:0]        i_count,
    output iol_pkg::t_cell_cmd  o_cmd,
    output logic [PW-1:0]       o_pos,
    output iol_pkg::t_status    o_status,
    output logic                o_is_read,
    output logic [CW-1:0]       o_count_next
);

    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          want_ins;
    logic          want_del;

    assign pos_ext = PW'(i_beat.position);
    assign cnt_ext = PW'(i_count);

    always_comb begin
        want_ins     = 1'b0;
        want_del     = 1'b0;
        o_is_read    = 1'b0;
        o_pos        = pos_ext;
        o_status     = iol_pkg::ST_OK;
        o_cmd        = '0;
        o_count_next = i_count;

        case (iol_pkg::t_action'(i_beat.action))
            iol_pkg::ACT_APPEND: begin
                want_ins = 1'b1;
                o_pos    = cnt_ext;
            end
            iol_pkg::ACT_INS_HEAD: begin
                want_ins = 1'b1;
                o_pos    = '0;
            end
            iol_pkg::ACT_REM_HEAD: begin
                want_del = 1'b1;
                o_pos    = '0;
            end
            iol_pkg::ACT_INS_AT: begin
                want_ins = 1'b1;
            end
            iol_pkg::ACT_REM_AT: begin
                want_del = 1'b1;
            end
            iol_pkg::ACT_READ_AT: begin
                o_is_read = 1'b1;
            end
            default: begin
                o_status = iol_pkg::ST_BADPOS;
            end
        endcase

        // The position check comes before the full check on inserts,
        // and the empty check before the position check on removes and reads.
        if (want_ins) begin
            if (o_pos > cnt_ext) begin
                o_status = iol_pkg::ST_BADPOS;
            end else if (i_count == FULL_CNT) begin
                o_status = iol_pkg::ST_FULL;
            end else begin
                o_cmd.ins    = 1'b1;
                o_count_next = i_count + CW'(1);
            end
        end else if (want_del || o_is_read) begin
            if (i_count == '0) begin
                o_status = iol_pkg::ST_EMPTY;
            end else if (o_pos >= cnt_ext) begin
                o_status = iol_pkg::ST_BADPOS;
            end else if (want_del) begin
                o_cmd.del    = 1'b1;
                o_count_next = i_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/indexed_ordered_list_core.sv */
// A result beat is registered and valid in the cycle after its input beat is accepted.
// One beat per cycle while the result side is not stalled; every insert or
// remove is a single shift of the whole cell row, done in the cycle of acceptance.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared and are only read below the count.
`default_nettype none
module indexed_ordered_list_core #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  iol_pkg::t_in_beat  i_beat,
    output logic               o_valid,
    input  wire                i_ready,
    output iol_pkg::t_out_beat o_beat
);

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;
    localparam int RD_CELLS = (CAPACITY < iol_pkg::POS_REACH) ? CAPACITY
                                                              : iol_pkg::POS_REACH;

    logic [CW-1:0]             r_count;
    logic                      r_out_valid;
    iol_pkg::t_out_beat        r_out;
    iol_pkg::t_out_beat        n_out;

    iol_pkg::t_cell_cmd        dec_cmd;
    iol_pkg::t_cell_cmd        cell_cmd;
    logic [PW-1:0]             dec_pos;
    iol_pkg::t_status          dec_status;
    logic                      dec_is_read;
    logic [CW-1:0]             dec_count_next;
    logic                      accept;

    logic signed [iol_pkg::DATA_W-1:0] cell_val [CAPACITY];
    logic signed [iol_pkg::DATA_W-1:0] rd_term  [RD_CELLS];
    logic signed [iol_pkg::DATA_W-1:0] rd_data;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    iol_decode #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .PW       (PW)
    ) u_decode (
        .i_beat       (i_beat),
        .i_count      (r_count),
        .o_cmd        (dec_cmd),
        .o_pos        (dec_pos),
        .o_status     (dec_status),
        .o_is_read    (dec_is_read),
        .o_count_next (dec_count_next)
    );

    always_comb begin
        cell_cmd     = dec_cmd;
        cell_cmd.ins = dec_cmd.ins && accept;
        cell_cmd.del = dec_cmd.del && accept;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [iol_pkg::DATA_W-1:0] left_val;
        logic signed [iol_pkg::DATA_W-1:0] right_val;

        if (g == 0) begin : g_head
            assign left_val = i_beat.item_value;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        iol_cell #(
            .INDEX (g),
            .PW    (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_pos   (dec_pos),
            .i_new   (i_beat.item_value),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g])
        );
    end

    // Only the cells that a position field can name take part in a read.
    for (genvar g = 0; g < RD_CELLS; g++) begin : g_rd
        assign rd_term[g] = (i_beat.position == iol_pkg::POS_W'(g)) ? cell_val[g] : '0;
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < RD_CELLS; k++) begin
            rd_data = rd_data | rd_term[k];
        end
    end

    always_comb begin
        n_out.status      = dec_status;
        n_out.entry_count = iol_pkg::CNT_OUT_W'(dec_count_next);
        if (!dec_is_read) begin
            n_out.read_value = '0;
        end else if (dec_status == iol_pkg::ST_OK) begin
            n_out.read_value = rd_data;
        end else begin
            n_out.read_value = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= dec_count_next;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule
`default_nettype wire

/* tb/iol_list_checker.sv */
`timescale 1ns / 1ps
module iol_list_checker #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  iol_pkg::t_in_beat  i_in_beat,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  iol_pkg::t_out_beat i_out_beat,
    output int                 o_fail_count,
    output int                 o_pending
);
    import iol_pkg::*;

    logic signed [DATA_W-1:0] cells [CAPACITY];
    int unsigned              held;
    t_out_beat                owed_beats [$];

    function automatic t_status insert_entry(int unsigned pos, logic signed [DATA_W-1:0] value);
        if (pos > held) return ST_BADPOS;
        if (held >= CAPACITY) return ST_FULL;
        for (int unsigned i = held; i > pos; i--) cells[i] = cells[i-1];
        cells[pos] = value;
        held++;
        return ST_OK;
    endfunction

    function automatic t_status remove_entry(int unsigned pos);
        if (held == 0) return ST_EMPTY;
        if (pos >= held) return ST_BADPOS;
        for (int unsigned i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
        held--;
        return ST_OK;
    endfunction

    // Applies one action to the shadow list and returns the beat it should produce.
    function automatic t_out_beat apply_action(t_in_beat b);
        t_out_beat r;
        t_status   st;
        r.read_value = '0;
        case (b.action)
            ACT_APPEND:   st = insert_entry(held, b.item_value);
            ACT_INS_HEAD: st = insert_entry(0, b.item_value);
            ACT_REM_HEAD: st = remove_entry(0);
            ACT_INS_AT:   st = insert_entry(b.position, b.item_value);
            ACT_REM_AT:   st = remove_entry(b.position);
            ACT_READ_AT: begin
                if (held == 0) begin
                    st = ST_EMPTY;
                    r.read_value = '1;
                end else if (b.position >= held) begin
                    st = ST_BADPOS;
                    r.read_value = '1;
                end else begin
                    st = ST_OK;
                    r.read_value = cells[b.position];
                end
            end
            default:      st = ST_BADPOS;
        endcase
        r.status      = st;
        r.entry_count = held[CNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        int        misses;
        misses = 0;
        if (!i_rst_n) begin
            owed_beats.delete();
            held = 0;
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // Results come back in order, so the oldest owed beat is always
            // the one that matches an output beat taken at this edge.
            if (i_out_valid && i_out_ready) begin
                if (owed_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_beat);
                    misses++;
                end else begin
                    want = owed_beats.pop_front();
                    if (i_out_beat.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_out_beat.status);
                        misses++;
                    end
                    if (i_out_beat.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, i_out_beat.read_value);
                        misses++;
                    end
                    if (i_out_beat.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, i_out_beat.entry_count);
                        misses++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) owed_beats.push_back(apply_action(i_in_beat));
            o_pending    <= owed_beats.size();
            o_fail_count <= o_fail_count + misses;
        end
    end

endmodule

/* tb/tb_indexed_ordered_list_core.sv */
`timescale 1ns / 1ps
module tb_indexed_ordered_list_core;
    import iol_pkg::*;

    localparam int RANDOM_BEATS = 1800;
    localparam int CHOKE_CYCLES = 80;
    localparam int LIMIT_CYCLES = 900_000;

    // Action codes outside the defined set; the block must reject them.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_beat;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_beat;

    int fail_count;
    int pending;
    int beats_sent;
    int choke_at;
    bit quiet;

    indexed_ordered_list_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_beat  (i_beat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_beat  (o_beat)
    );

    iol_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_beat    (i_beat),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_beat   (o_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("FAILURE");
        $finish;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_beat mk_beat(logic [ACTION_W-1:0] act, int pos,
                                         logic signed [DATA_W-1:0] value);
        t_in_beat b;
        b.action     = act;
        b.position   = POS_W'(pos);
        b.item_value = value;
        return b;
    endfunction

    function automatic t_in_beat random_beat(bit grow);
        int                       r;
        logic [ACTION_W-1:0]      act;
        int                       pos;
        logic signed [DATA_W-1:0] value;
        r = $urandom_range(0, 99);
        if (grow)
            act = r < 25 ? ACT_APPEND : r < 45 ? ACT_INS_HEAD : r < 65 ? ACT_INS_AT :
                  r < 72 ? ACT_REM_HEAD : r < 80 ? ACT_REM_AT : r < 95 ? ACT_READ_AT :
                  ($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B);
        else
            act = r < 8 ? ACT_APPEND : r < 14 ? ACT_INS_HEAD : r < 20 ? ACT_INS_AT :
                  r < 45 ? ACT_REM_HEAD : r < 70 ? ACT_REM_AT : r < 95 ? ACT_READ_AT :
                  ($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B);
        pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
        case ($urandom_range(0, 19))
            0:       value = VAL_MIN;
            1:       value = VAL_MAX;
            2:       value = '1;
            3:       value = '0;
            default: value = $urandom;
        endcase
        return mk_beat(act, pos, value);
    endfunction

    task automatic send_beat(t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= b;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus a few long hold-offs that back the block up.
    initial begin
        int run;
        int gap;
        i_ready  <= 1'b0;
        choke_at  = 300;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (beats_sent >= choke_at) begin
                i_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
                choke_at += 600;
            end else begin
                run = $urandom_range(1, 20);
                i_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        t_in_beat directed [$];
        int       left;
        int       len;
        bit       grow;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_beat     <= '0;
        beats_sent  = 0;
        quiet       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-list cases first, then a short list with both value extremes.
        directed.push_back(mk_beat(ACT_READ_AT,  0, 0));
        directed.push_back(mk_beat(ACT_REM_HEAD, 0, 0));
        directed.push_back(mk_beat(ACT_REM_AT,   0, 0));
        directed.push_back(mk_beat(ACT_INS_AT,   1, 32'sh1234_5678));
        directed.push_back(mk_beat(ACT_INS_AT,   0, VAL_MIN));
        directed.push_back(mk_beat(ACT_APPEND,   0, VAL_MAX));
        directed.push_back(mk_beat(ACT_INS_HEAD, 0, 0));
        directed.push_back(mk_beat(ACT_INS_AT,   3, -1));
        directed.push_back(mk_beat(ACT_INS_AT,   31, 7));
        directed.push_back(mk_beat(ACT_READ_AT,  0, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  1, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  2, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  3, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  4, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  31, 0));
        directed.push_back(mk_beat(ACT_REM_AT,   4, 0));
        directed.push_back(mk_beat(ACT_REM_AT,   1, 0));
        directed.push_back(mk_beat(ACT_SPARE_A,  2, 32'sh0F0F_0F0F));
        directed.push_back(mk_beat(ACT_SPARE_B,  2, 32'sh0F0F_0F0F));
        directed.push_back(mk_beat(ACT_INS_AT,   1, 32'sh5A5A_5A5A));
        directed.push_back(mk_beat(ACT_READ_AT,  1, 0));
        directed.push_back(mk_beat(ACT_REM_AT,   3, 0));
        directed.push_back(mk_beat(ACT_REM_HEAD, 0, 0));
        directed.push_back(mk_beat(ACT_READ_AT,  16, 0));
        foreach (directed[k]) send_beat(directed[k]);
        drain();

        // Alternate growing and shrinking phases so the list keeps hitting
        // both the full and the empty boundaries.
        left = RANDOM_BEATS;
        grow = 1'b1;
        while (left > 0) begin
            len   = $urandom_range(40, 150);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && left > 0; k++) begin
                send_beat(random_beat(grow));
                left--;
            end
            grow = !grow;
            if ($urandom_range(0, 2) == 0) drain();
        end
        drain();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
sv/iol_pkg.sv
sv/iol_cell.sv
sv/iol_decode.sv
sv/indexed_ordered_list_core.sv
tb/iol_list_checker.sv
tb/tb_indexed_ordered_list_core.sv
